// ===== sv/magic_type_length_deframer_top_defines.svh =====
// assertion macros for the magic/type/length deframer
// used by magic_type_length_deframer_top, no other dependencies
`ifndef MAGIC_TYPE_LENGTH_DEFRAMER_TOP_DEFINES_SVH
`define MAGIC_TYPE_LENGTH_DEFRAMER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MTLD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mtld assertion failed");

// next-cycle implication, disabled during reset
`define MTLD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mtld assertion failed");

`endif

// ===== sv/mtld_pkg.sv =====
// shared types and constants for the magic/type/length deframer
// no dependencies
package mtld_pkg;

    localparam logic [3:0]  HDR_BYTES      = 4'd13;
    localparam logic [3:0]  MAGIC_BYTES    = 4'd4;
    localparam logic [3:0]  TYPE_POS       = 4'd4;
    localparam logic [3:0]  SESSION_END    = 4'd9;
    localparam logic [3:0]  HDR_LAST_POS   = 4'd12;
    localparam logic [31:0] MAGIC_RESET    = 32'h4642_4541;
    localparam int          CMDQ_DEPTH_DEF = 4;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_STATUS  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SHORT     = 2'd1,
        ST_BAD_MAGIC = 2'd2,
        ST_TRUNC     = 2'd3
    } t_status;

    typedef enum logic {
        BK_ITEM   = 1'b0,
        BK_STATUS = 1'b1
    } t_back_state;

    // one classified input byte: an optional header/payload result and an optional status
    typedef struct packed {
        logic        emit_item;
        t_kind       item_kind;
        logic [7:0]  msg_type;
        logic [31:0] session;
        logic [31:0] payload_length;
        logic [7:0]  data_byte;
        logic        emit_status;
        t_status     status;
    } t_cmd;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  msg_type;
        logic [31:0] session;
        logic [31:0] payload_length;
        logic [7:0]  data_byte;
        t_status     status;
        logic        end_of_run;
    } t_res;

endpackage

// ===== sv/mtld_front.sv =====
// front end: header capture, magic check, payload countdown, classification
// depends on mtld_pkg
module mtld_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [31:0]     i_cfg_wr_data,
    input  logic            i_accept,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    output logic            o_cmd_vld,
    output mtld_pkg::t_cmd  o_cmd
);
    import mtld_pkg::*;

    logic [31:0] r_magic;
    logic [3:0]  r_pos,  n_pos;
    logic        r_mm,   n_mm;
    logic [7:0]  r_type, n_type;
    logic [31:0] r_ses,  n_ses;
    logic [31:0] r_len,  n_len;
    logic [31:0] r_rem,  n_rem;
    logic [7:0]  want;
    t_cmd        cmd;

    always_comb begin
        case (r_pos[1:0])
            2'd0:    want = r_magic[31:24];
            2'd1:    want = r_magic[23:16];
            2'd2:    want = r_magic[15:8];
            default: want = r_magic[7:0];
        endcase
    end

    always_comb begin
        n_pos  = (r_pos < HDR_BYTES) ? r_pos + 4'd1 : r_pos;
        n_mm   = r_mm;
        n_type = r_type;
        n_ses  = r_ses;
        n_len  = r_len;
        n_rem  = r_rem;

        cmd                = '0;
        cmd.item_kind      = KIND_HEADER;
        cmd.status         = ST_OK;

        if (r_pos < MAGIC_BYTES) begin
            if (i_byte != want) begin
                n_mm = 1'b0;
            end
        end else if (r_pos == TYPE_POS) begin
            n_type = i_byte;
        end else if (r_pos < SESSION_END) begin
            n_ses = {r_ses[23:0], i_byte};
        end else if (r_pos < HDR_BYTES) begin
            n_len = {r_len[23:0], i_byte};
            if (r_pos == HDR_LAST_POS && r_mm) begin
                n_rem              = n_len;
                cmd.emit_item      = 1'b1;
                cmd.item_kind      = KIND_HEADER;
                cmd.msg_type       = r_type;
                cmd.session        = r_ses;
                cmd.payload_length = n_len;
            end
        end else if (r_mm && r_rem != 32'd0) begin
            cmd.emit_item = 1'b1;
            cmd.item_kind = KIND_PAYLOAD;
            cmd.data_byte = i_byte;
            n_rem         = r_rem - 32'd1;
        end

        if (i_last) begin
            cmd.emit_status = 1'b1;
            if (n_pos < HDR_BYTES) begin
                cmd.status = ST_SHORT;
            end else if (!n_mm) begin
                cmd.status = ST_BAD_MAGIC;
            end else if (n_rem != 32'd0) begin
                cmd.status = ST_TRUNC;
            end else begin
                cmd.status = ST_OK;
            end
            n_pos  = '0;
            n_mm   = 1'b1;
            n_type = '0;
            n_ses  = '0;
            n_len  = '0;
            n_rem  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= MAGIC_RESET;
        end else if (i_cfg_wr_en) begin
            r_magic <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_mm   <= 1'b1;
            r_type <= '0;
            r_ses  <= '0;
            r_len  <= '0;
            r_rem  <= '0;
        end else if (i_accept) begin
            r_pos  <= n_pos;
            r_mm   <= n_mm;
            r_type <= n_type;
            r_ses  <= n_ses;
            r_len  <= n_len;
            r_rem  <= n_rem;
        end
    end

    assign o_cmd_vld = i_accept && (cmd.emit_item || cmd.emit_status);
    assign o_cmd     = cmd;

endmodule

// ===== sv/mtld_cmdq.sv =====
// short command queue between front and back end
// depends on mtld_pkg
module mtld_cmdq #(
    parameter int DEPTH = mtld_pkg::CMDQ_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_en,
    input  mtld_pkg::t_cmd  i_wr_data,
    input  logic            i_rd_en,
    output mtld_pkg::t_cmd  o_rd_data,
    output logic            o_full,
    output logic            o_empty
);
    import mtld_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          wr, rd;

    assign wr = i_wr_en && !o_full;
    assign rd = i_rd_en && !o_empty;

    always_comb begin
        n_wr  = wr ? ((r_wr == LAST_IDX) ? '0 : r_wr + PW'(1)) : r_wr;
        n_rd  = rd ? ((r_rd == LAST_IDX) ? '0 : r_rd + PW'(1)) : r_rd;
        n_cnt = r_cnt + CW'(wr) - CW'(rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_mem[r_rd];
    assign o_full    = (r_cnt == FULL_CNT);
    assign o_empty   = (r_cnt == '0);

endmodule

// ===== sv/mtld_back.sv =====
// back end: expands queued commands into result beats through an output register
// depends on mtld_pkg
module mtld_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_vld,
    input  mtld_pkg::t_cmd  i_cmd,
    output logic            o_cmd_pop,
    input  logic            i_pop,
    output logic            o_empty,
    output mtld_pkg::t_res  o_res
);
    import mtld_pkg::*;

    t_back_state r_state, n_state;
    logic        r_vld, n_vld;
    t_res        r_res, n_res;
    logic        load, fire, take_item;

    assign load = !r_vld || i_pop;
    assign fire = load && i_cmd_vld;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_ITEM: begin
                if (fire && i_cmd.emit_item && i_cmd.emit_status) begin
                    n_state = BK_STATUS;
                end
            end
            BK_STATUS: begin
                if (fire) begin
                    n_state = BK_ITEM;
                end
            end
            default: n_state = BK_ITEM;
        endcase
    end

    always_comb begin
        take_item = (r_state == BK_ITEM) && i_cmd.emit_item;
        o_cmd_pop = fire && !(take_item && i_cmd.emit_status);
        n_vld     = fire ? 1'b1 : (i_pop ? 1'b0 : r_vld);
        n_res     = r_res;
        if (fire) begin
            n_res        = '0;
            n_res.status = ST_OK;
            if (take_item) begin
                n_res.kind           = i_cmd.item_kind;
                n_res.msg_type       = i_cmd.msg_type;
                n_res.session        = i_cmd.session;
                n_res.payload_length = i_cmd.payload_length;
                n_res.data_byte      = i_cmd.data_byte;
            end else begin
                n_res.kind       = KIND_STATUS;
                n_res.status     = i_cmd.status;
                n_res.end_of_run = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_ITEM;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vld   <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_empty = !r_vld;
    assign o_res   = r_res;

endmodule

// ===== sv/magic_type_length_deframer_top.sv =====
// Magic/type/length deframer. Bytes of a buffer enter through push/full, one
// byte per cycle with no gaps needed; full rises only when the command queue
// (CMDQ_DEPTH entries) backs up behind a stalled result side. Results leave
// through empty/pop from an output register, one beat per cycle while pop is held. A
// byte that yields a header or payload beat and also closes the buffer yields two
// beats, one after the other; the queue absorbs that. An accepted byte reaches its first
// result beat through the command queue and then the output register. Payload beats
// leave before truncation is known: drop them when the closing status is not ok.
// Depends on mtld_pkg, mtld_front, mtld_cmdq, mtld_back and the defines header.
`include "magic_type_length_deframer_top_defines.svh"

module magic_type_length_deframer_top #(
    parameter int CMDQ_DEPTH = mtld_pkg::CMDQ_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_msg_type,
    output logic [31:0] o_session,
    output logic [31:0] o_payload_length,
    output logic [7:0]  o_data_byte,
    output logic [1:0]  o_status,
    output logic        o_end_of_run
);
    import mtld_pkg::*;

    logic accept;
    logic cmd_vld;
    t_cmd cmd_in;
    t_cmd cmd_head;
    logic q_empty;
    logic q_pop;
    t_res res;

    assign accept = push && !full;

    mtld_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_byte        (i_in_byte),
        .i_last        (i_in_last),
        .o_cmd_vld     (cmd_vld),
        .o_cmd         (cmd_in)
    );

    mtld_cmdq #(
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (cmd_vld),
        .i_wr_data (cmd_in),
        .i_rd_en   (q_pop),
        .o_rd_data (cmd_head),
        .o_full    (full),
        .o_empty   (q_empty)
    );

    mtld_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (!q_empty),
        .i_cmd     (cmd_head),
        .o_cmd_pop (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (res)
    );

    assign o_kind           = res.kind;
    assign o_msg_type       = res.msg_type;
    assign o_session        = res.session;
    assign o_payload_length = res.payload_length;
    assign o_data_byte      = res.data_byte;
    assign o_status         = res.status;
    assign o_end_of_run     = res.end_of_run;

    `MTLD_ASSERT_SAME(a_eor_only_on_status, i_clk, i_rst_n, !empty, ((o_kind == KIND_STATUS) == o_end_of_run))
    `MTLD_ASSERT_NEXT(a_last_leaves_work, i_clk, i_rst_n, accept && i_in_last, (!q_empty || !empty))
    `MTLD_ASSERT_SAME(a_idle_not_full, i_clk, i_rst_n, q_empty, !full)

endmodule

// ===== verif/magic_type_length_deframer_top_tb.sv =====
// testbench for magic_type_length_deframer_top: random buffers, a scoreboard class
// predicting header, payload and status beats; depends on mtld_pkg and the top level
`timescale 1ns / 100ps

module magic_type_length_deframer_top_tb;
    import mtld_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int          PHASE_BYTES = 380;
    localparam int          MAX_GAP     = 11;

    typedef enum int {
        SHAPE_GOOD,
        SHAPE_BAD_MAGIC,
        SHAPE_SHORT,
        SHAPE_NOISE
    } t_frame_shape;

    class deframe_scoreboard;
        logic [31:0] magic;
        logic [3:0]  hdr_pos;
        logic        magic_ok;
        logic [7:0]  type_hold;
        logic [31:0] session_acc;
        logic [31:0] length_acc;
        logic [31:0] remaining;
        t_res        expected_beats[$];
        int          errors;

        function new();
            magic  = MAGIC_RESET;
            errors = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            hdr_pos     = '0;
            magic_ok    = 1'b1;
            type_hold   = '0;
            session_acc = '0;
            length_acc  = '0;
            remaining   = '0;
        endfunction

        function void write_magic(logic [31:0] value);
            magic = value;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            t_res r;
            r = '0;
            if (hdr_pos < MAGIC_BYTES) begin
                if (b != magic[31 - 8 * hdr_pos -: 8]) magic_ok = 1'b0;
            end else if (hdr_pos == TYPE_POS) begin
                type_hold = b;
            end else if (hdr_pos < SESSION_END) begin
                session_acc = {session_acc[23:0], b};
            end else if (hdr_pos < HDR_BYTES) begin
                length_acc = {length_acc[23:0], b};
                if (hdr_pos == HDR_LAST_POS && magic_ok) begin
                    remaining        = length_acc;
                    r.kind           = KIND_HEADER;
                    r.msg_type       = type_hold;
                    r.session        = session_acc;
                    r.payload_length = length_acc;
                    expected_beats.insert(expected_beats.size(), r);
                end
            end else if (magic_ok && remaining != 0) begin
                r.kind      = KIND_PAYLOAD;
                r.data_byte = b;
                expected_beats.insert(expected_beats.size(), r);
                remaining = remaining - 1;
            end
            if (hdr_pos < HDR_BYTES) hdr_pos = hdr_pos + 4'd1;

            if (last) begin
                r            = '0;
                r.kind       = KIND_STATUS;
                r.end_of_run = 1'b1;
                if (hdr_pos < HDR_BYTES)  r.status = ST_SHORT;
                else if (!magic_ok)       r.status = ST_BAD_MAGIC;
                else if (remaining != 0)  r.status = ST_TRUNC;
                else                      r.status = ST_OK;
                expected_beats.insert(expected_beats.size(), r);
                clear_frame();
            end
        endfunction

        function void check_beat(t_res got);
            t_res want;
            if (expected_beats.size() == 0) begin
                $error("result beat with nothing expected: kind %0d", got.kind);
                errors++;
                return;
            end
            want = expected_beats.pop_front();
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                errors++;
            end
            if (got.msg_type !== want.msg_type) begin
                $error("msg_type: expected %0h, actual %0h", want.msg_type, got.msg_type);
                errors++;
            end
            if (got.session !== want.session) begin
                $error("session: expected %0h, actual %0h", want.session, got.session);
                errors++;
            end
            if (got.payload_length !== want.payload_length) begin
                $error("payload_length: expected %0h, actual %0h",
                       want.payload_length, got.payload_length);
                errors++;
            end
            if (got.data_byte !== want.data_byte) begin
                $error("data_byte: expected %0h, actual %0h", want.data_byte, got.data_byte);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.end_of_run !== want.end_of_run) begin
                $error("end_of_run: expected %0d, actual %0d", want.end_of_run, got.end_of_run);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [31:0] i_cfg_wr_data;
    logic        push;
    logic        full;
    logic [7:0]  i_in_byte;
    logic        i_in_last;
    logic        empty;
    logic        pop;
    logic [1:0]  o_kind;
    logic [7:0]  o_msg_type;
    logic [31:0] o_session;
    logic [31:0] o_payload_length;
    logic [7:0]  o_data_byte;
    logic [1:0]  o_status;
    logic        o_end_of_run;

    deframe_scoreboard sb;
    logic [7:0]        frame_bytes[$];
    int                bytes_sent   = 0;
    int                tx_calm      = 0;
    int                rx_calm      = 0;
    int                rx_hold      = 0;
    int unsigned       cycle_count  = 0;

    magic_type_length_deframer_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .push            (push),
        .full            (full),
        .i_in_byte       (i_in_byte),
        .i_in_last       (i_in_last),
        .empty           (empty),
        .pop             (pop),
        .o_kind          (o_kind),
        .o_msg_type      (o_msg_type),
        .o_session       (o_session),
        .o_payload_length(o_payload_length),
        .o_data_byte     (o_data_byte),
        .o_status        (o_status),
        .o_end_of_run    (o_end_of_run)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("magic_type_length_deframer_top test failed");
            $finish;
        end
    end

    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 30) == 0) calm_left = $urandom_range(10, 50);
        return $urandom_range(0, MAX_GAP);
    endfunction

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = draw_gap(tx_calm);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push      <= 1'b1;
        i_in_byte <= b;
        i_in_last <= last;
        do @(posedge i_clk); while (full);
        sb.note_byte(b, last);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_buffer();
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    function automatic void add_header(logic [31:0] m, logic [7:0] ty, logic [31:0] ses,
                                       logic [31:0] len);
        for (int i = 3; i >= 0; i--) frame_bytes.insert(frame_bytes.size(), m[8 * i +: 8]);
        frame_bytes.insert(frame_bytes.size(), ty);
        for (int i = 3; i >= 0; i--) frame_bytes.insert(frame_bytes.size(), ses[8 * i +: 8]);
        for (int i = 3; i >= 0; i--) frame_bytes.insert(frame_bytes.size(), len[8 * i +: 8]);
    endfunction

    task automatic send_random_frame(input logic [31:0] magic);
        t_frame_shape shape;
        int           pick;
        int           cut;
        int           n_payload;
        logic [31:0]  m;
        logic [31:0]  declared;
        pick = $urandom_range(0, 99);
        if (pick < 60)      shape = SHAPE_GOOD;
        else if (pick < 72) shape = SHAPE_BAD_MAGIC;
        else if (pick < 86) shape = SHAPE_SHORT;
        else                shape = SHAPE_NOISE;
        frame_bytes.delete();
        m    = magic;
        pick = $urandom_range(0, 9);
        if (pick < 7)       declared = $urandom_range(0, 12);
        else if (pick == 7) declared = $urandom();
        else                declared = $urandom_range(13, 40);
        if (declared > 40) begin
            n_payload = $urandom_range(0, 8);
        end else begin
            pick = $urandom_range(0, 9);
            if (pick < 6 || declared == 0) n_payload = declared;
            else if (pick < 8)             n_payload = declared + $urandom_range(1, 4);
            else                           n_payload = declared - $urandom_range(1, declared);
        end
        case (shape)
            SHAPE_NOISE: begin
                repeat ($urandom_range(1, 20))
                    frame_bytes.insert(frame_bytes.size(), 8'($urandom()));
            end
            SHAPE_SHORT: begin
                add_header(m, 8'($urandom()), $urandom(), declared);
                cut = $urandom_range(1, 12);
                while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
            end
            default: begin
                if (shape == SHAPE_BAD_MAGIC)
                    m[8 * $urandom_range(0, 3) +: 8] ^= 8'($urandom_range(1, 255));
                add_header(m, 8'($urandom()), $urandom(), declared);
                repeat (n_payload) frame_bytes.insert(frame_bytes.size(), 8'($urandom()));
            end
        endcase
        send_buffer();
    endtask

    task automatic write_magic_when_idle(input logic [31:0] value);
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (6) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.write_magic(value);
    endtask

    // result side
    initial begin
        int   gap;
        t_res got;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = draw_gap(rx_calm);
            if (rx_hold > 0) begin
                pop <= 1'b0;
                repeat (rx_hold) @(negedge i_clk);
                rx_hold = 0;
            end else if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            got = t_res'({o_kind, o_msg_type, o_session, o_payload_length,
                          o_data_byte, o_status, o_end_of_run});
            sb.check_beat(got);
            @(negedge i_clk);
        end
    end

    initial begin
        logic [31:0] magic_plan[5];
        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        push          = 1'b0;
        pop           = 1'b0;
        i_in_byte     = '0;
        i_in_last     = 1'b0;
        magic_plan    = '{MAGIC_RESET, 32'h0000_0000, 32'hFFFF_FFFF, $urandom(), MAGIC_RESET};
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // short buffer with mismatching magic
        frame_bytes = '{8'h00, 8'hFF};
        send_buffer();
        // zero length, all-ones header fields, header and status beats from the same byte
        frame_bytes.delete();
        add_header(MAGIC_RESET, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send_buffer();
        // one-byte buffer
        frame_bytes = '{8'h46};
        send_buffer();

        for (int phase = 0; phase < 5; phase++) begin
            if (phase > 0) write_magic_when_idle(magic_plan[phase]);
            if (phase == 1) begin
                // long result-side stall while the input keeps streaming
                rx_hold = 400;
                tx_calm = 150;
            end
            bytes_sent = 0;
            while (bytes_sent < PHASE_BYTES) send_random_frame(magic_plan[phase]);
        end

        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0)
            $display("magic_type_length_deframer_top test passed");
        else
            $display("magic_type_length_deframer_top test failed");
        $finish;
    end

endmodule
